// File: design/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the preference ring top-k unit.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef logic signed [31:0] score_t;

endpackage

// File: design/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module prt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/preference_ring_topk_unit.sv
// ----------------------------------------------------------------------------
// preference_ring_topk_unit
// Ring buffer of signed Q16.16 scores with running minimum, mean and top-k.
// ----------------------------------------------------------------------------
// Push: RAM write on the accept edge, a scan over every slot for minimum and sum,
// a restoring divide for the mean, then a decide state and an output state.
// Query: same scan and divide (divide skipped when empty), then each ranked index
// takes an exchange pass and an output state; one item at a time.
// Reset clears used marks, pointer, count and minimum; the RAM is not cleared.
module preference_ring_topk_unit #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  prt_pkg::score_t       preference,
    input  logic [6:0]            k_request,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status,
    output logic [3:0]            slot_index,
    output logic                  index_valid,
    output logic                  last,
    output prt_pkg::score_t       min_score,
    output prt_pkg::score_t       mean_score,
    output logic [4:0]            occupancy
);
    import prt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 32 + CW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_DECID = 4'd3;
    localparam logic [3:0] S_SEL   = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;

    logic [3:0]       state_reg, state_next;
    logic [DEPTH-1:0] used_reg;
    logic [AW-1:0]    wp_reg;
    logic [CW-1:0]    count_reg;
    score_t           min_reg;
    logic             req_reg;
    logic [6:0]       k_reg;
    logic [CW-1:0]    emitted_reg;

    // used slots in ascending order, then permuted by the exchange passes
    logic [AW-1:0]    order_reg [DEPTH];
    logic [CW-1:0]    n_reg;
    score_t           cur_score_reg;

    // scan counter over addresses; issue address is scan_reg (order_reg[scan_reg] in select), read data is registered
    logic [CW-1:0]    scan_reg;
    logic [AW-1:0]    lag_addr_reg;
    logic             lag_ok_reg;
    logic             have_reg;
    score_t           acc_min_reg;
    logic signed [SW-1:0] sum_reg;

    // divider
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    quo_reg;
    logic [5:0]       div_cnt_reg;
    logic             neg_reg;
    score_t           mean_reg;

    // output register
    logic             ov_reg;
    logic             st_reg;
    logic [AW-1:0]    si_reg;
    logic             iv_reg;
    logic             last_reg;

    // score RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;
    score_t           rd_score;

    prt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (preference),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_score  = score_t'(ram_rdata);
    assign ram_we    = in_valid && in_ready && (req_type == REQ_PUSH);
    assign ram_waddr = wp_reg;
    assign ram_raddr = (state_reg == S_SEL) ? order_reg[scan_reg[AW-1:0]]
                                            : scan_reg[AW-1:0];

    assign in_ready    = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign slot_index  = 4'(si_reg);
    assign index_valid = iv_reg;
    assign last        = last_reg;
    assign min_score   = min_reg;
    assign mean_score  = mean_reg;
    assign occupancy   = 5'(count_reg);

    logic          scan_done;
    logic          scan_fin;
    logic          sel_done;
    logic          sel_fin;
    logic          lag_hit;
    logic [SW-1:0] abs_sum;
    logic [SW-1:0] rem_shift;
    logic [CW-1:0] k_eff;
    logic [AW-1:0] pos;

    assign scan_done = (scan_reg == CW'(DEPTH));
    assign scan_fin  = scan_done && !lag_ok_reg;
    assign sel_done  = (scan_reg == n_reg);
    assign sel_fin   = sel_done && !lag_ok_reg;
    assign lag_hit   = lag_ok_reg && used_reg[lag_addr_reg];
    assign abs_sum   = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign rem_shift = {rem_reg[SW-2:0], quo_reg[SW-1]};
    assign k_eff     = (7'(count_reg) < k_reg) ? count_reg : CW'(k_reg);
    assign pos       = emitted_reg[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_fin)
                begin
                    state_next = (count_reg == '0) ? S_DECID : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == 6'(SW - 1))
                begin
                    state_next = S_DECID;
                end
            end
            S_DECID:
            begin
                if (req_reg == REQ_QUERY && k_reg != '0 && k_eff != '0)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SEL:
            begin
                if (sel_fin)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    if (req_reg == REQ_QUERY && k_reg != '0 && k_eff != '0
                        && (emitted_reg + 1'b1) != k_eff)
                    begin
                        state_next = S_SEL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            wp_reg      <= '0;
            count_reg   <= '0;
            min_reg     <= '0;
            ov_reg      <= 1'b0;
            scan_reg    <= '0;
            lag_ok_reg  <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg     <= req_type;
                        k_reg       <= k_request;
                        scan_reg    <= '0;
                        lag_ok_reg  <= 1'b0;
                        have_reg    <= 1'b0;
                        sum_reg     <= '0;
                        n_reg       <= '0;
                        emitted_reg <= '0;
                        si_reg      <= wp_reg;
                        if (req_type == REQ_PUSH)
                        begin
                            used_reg[wp_reg] <= 1'b1;
                            if (!used_reg[wp_reg])
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        end
                    end
                end
                S_SCAN:
                begin
                    // one address issued per cycle, data checked in the next cycle
                    lag_addr_reg <= scan_reg[AW-1:0];
                    lag_ok_reg   <= !scan_done;
                    if (!scan_done)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        if (used_reg[scan_reg[AW-1:0]])
                        begin
                            order_reg[n_reg[AW-1:0]] <= scan_reg[AW-1:0];
                            n_reg                    <= n_reg + 1'b1;
                        end
                    end
                    if (lag_hit)
                    begin
                        sum_reg <= sum_reg + SW'(rd_score);
                        if (!have_reg || rd_score < acc_min_reg)
                        begin
                            acc_min_reg <= rd_score;
                        end
                        have_reg <= 1'b1;
                    end
                    if (scan_fin)
                    begin
                        if (req_reg == REQ_PUSH)
                        begin
                            min_reg <= have_reg ? acc_min_reg : '0;
                        end
                        neg_reg     <= sum_reg[SW-1];
                        quo_reg     <= abs_sum;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        mean_reg    <= '0;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (rem_shift >= SW'(count_reg))
                    begin
                        rem_reg <= rem_shift - SW'(count_reg);
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                S_DECID:
                begin
                    if (count_reg != '0)
                    begin
                        mean_reg <= neg_reg ? score_t'(-quo_reg[31:0]) : score_t'(quo_reg[31:0]);
                    end
                    scan_reg   <= '0;
                    lag_ok_reg <= 1'b0;
                    have_reg   <= 1'b0;
                end
                S_SEL:
                begin
                    // exchange pass for one position: later entries swap in when
                    // strictly greater than the current holder
                    lag_addr_reg <= scan_reg[AW-1:0];
                    lag_ok_reg   <= !sel_done;
                    if (!sel_done)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (lag_ok_reg)
                    begin
                        if (lag_addr_reg == pos)
                        begin
                            cur_score_reg <= rd_score;
                        end
                        else if (rd_score > cur_score_reg)
                        begin
                            order_reg[pos]          <= order_reg[lag_addr_reg];
                            order_reg[lag_addr_reg] <= order_reg[pos];
                            cur_score_reg           <= rd_score;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg     <= 1'b1;
                        scan_reg   <= emitted_reg + 1'b1;
                        lag_ok_reg <= 1'b0;
                        have_reg   <= 1'b0;
                        if (req_reg == REQ_PUSH)
                        begin
                            st_reg   <= STATUS_OK;
                            iv_reg   <= 1'b1;
                            last_reg <= 1'b1;
                        end
                        else if (k_reg == '0)
                        begin
                            st_reg   <= STATUS_INVALID;
                            si_reg   <= '0;
                            iv_reg   <= 1'b0;
                            last_reg <= 1'b1;
                        end
                        else if (k_eff == '0)
                        begin
                            st_reg   <= STATUS_OK;
                            si_reg   <= '0;
                            iv_reg   <= 1'b0;
                            last_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg      <= STATUS_OK;
                            si_reg      <= order_reg[pos];
                            iv_reg      <= 1'b1;
                            last_reg    <= (emitted_reg + 1'b1 == k_eff);
                            emitted_reg <= emitted_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: design/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks for the preference ring top-k unit, bound to the top.
// ----------------------------------------------------------------------------
module prt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       status,
    input logic       index_valid,
    input logic       last,
    input logic [4:0] occupancy
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // an error result is always final and carries no slot
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !index_valid)
        else $error("bad error result");

    // occupancy never exceeds sixteen while a result is shown
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= 5'd16)
        else $error("occupancy out of range");

    // no new item taken while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted with result pending");

endmodule

bind preference_ring_topk_unit prt_checker u_prt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .index_valid (index_valid),
    .last        (last),
    .occupancy   (occupancy)
);
